/* rtl/uka_pkg.sv */
package uka_pkg;

  localparam int TableDepthDef   = 256;
  localparam int KeyHalfWidthDef = 32;
  localparam int WordWidth       = 32;
  localparam int IdWidth         = 8;

  typedef struct packed {
    logic flush;
    logic insert;
  } ctrl_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StWalk = 3'b010,
    StDone = 3'b100
  } state_e;

endpackage

/* rtl/unique_key_id_assigner.sv */
// channel  dir  tdata (low bit up)                       tuser (low bit up)
// s_axis   in   stiffness_bits[31:0], rest_angle_bits     start_of_set
// m_axis   out  type_id[7:0]                              new_type, overflow
//
// A request's key walks the row of key cells, one cell per clock.
// m_axis_tvalid rises once the walk reaches index k for a request that hits at index k,
// or reaches index used on a miss, used being the number of stored keys; the result
// passes through the pending register and then the holding register.
// One request is in the row at a time; the result waits until the holding register is
// free, and the next request is taken once it has moved there, even while m_axis is stalled.
// Reset empties the table at once; no clearing pass.
module unique_key_id_assigner #(
  parameter int TABLE_DEPTH    = uka_pkg::TableDepthDef,
  parameter int KEY_HALF_WIDTH = uka_pkg::KeyHalfWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [2*uka_pkg::WordWidth-1:0]  s_axis_tdata,  // stiffness_bits, rest_angle_bits
  input  logic                             s_axis_tuser,  // start_of_set
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [uka_pkg::IdWidth-1:0]      m_axis_tdata,  // type_id
  output logic [1:0]                       m_axis_tuser   // new_type, overflow
);
  import uka_pkg::*;

  localparam int KeyWidth = 2 * KEY_HALF_WIDTH;

  ctrl_t               ctrl;
  logic                in_ready;
  logic                hit_any;
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic                tok_act [TABLE_DEPTH];
  logic [KeyWidth-1:0] tok_key [TABLE_DEPTH];

  assign tok_act[0] = s_axis_tvalid & in_ready;
  assign tok_key[0] = {s_axis_tdata[KEY_HALF_WIDTH-1:0],
                       s_axis_tdata[WordWidth +: KEY_HALF_WIDTH]};
  assign hit_any    = |hit_vec;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i < TABLE_DEPTH - 1) begin : g_mid
      uka_cell #(.KeyWidth(KeyWidth)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .tok_act_i (tok_act[i]),
        .tok_key_i (tok_key[i]),
        .tok_act_o (tok_act[i+1]),
        .tok_key_o (tok_key[i+1]),
        .hit_o     (hit_vec[i])
      );
    end else begin : g_last
      uka_cell #(.KeyWidth(KeyWidth)) u_cell (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .ctrl_i    (ctrl),
        .tok_act_i (tok_act[i]),
        .tok_key_i (tok_key[i]),
        .tok_act_o (),
        .tok_key_o (),
        .hit_o     (hit_vec[i])
      );
    end
  end

  uka_ctrl #(.TableDepth(TABLE_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .start_i     (s_axis_tuser),
    .in_ready_o  (in_ready),
    .hit_i       (hit_any),
    .ctrl_o      (ctrl),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_id_o    (m_axis_tdata),
    .out_new_o   (m_axis_tuser[0]),
    .out_ovf_o   (m_axis_tuser[1])
  );

  assign s_axis_tready = in_ready;

endmodule

/* rtl/uka_cell.sv */
module uka_cell #(
  parameter int KeyWidth = 2 * uka_pkg::KeyHalfWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  uka_pkg::ctrl_t      ctrl_i,
  input  logic                tok_act_i,
  input  logic [KeyWidth-1:0] tok_key_i,
  output logic                tok_act_o,
  output logic [KeyWidth-1:0] tok_key_o,
  output logic                hit_o
);
  import uka_pkg::*;

  logic                tok_act_q;
  logic [KeyWidth-1:0] tok_key_q;
  logic [KeyWidth-1:0] key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_act_q <= 1'b0;
    end else begin
      tok_act_q <= tok_act_i & ~ctrl_i.flush;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_key_q <= tok_key_i;
    if (tok_act_q && ctrl_i.insert) begin
      key_q <= tok_key_q;
    end
  end

  assign hit_o     = tok_act_q & (key_q == tok_key_q);
  assign tok_act_o = tok_act_q & ~ctrl_i.flush;
  assign tok_key_o = tok_key_q;

endmodule

/* rtl/uka_ctrl.sv */
module uka_ctrl #(
  parameter int TableDepth = uka_pkg::TableDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         start_i,
  output logic                         in_ready_o,
  input  logic                         hit_i,
  output uka_pkg::ctrl_t               ctrl_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [uka_pkg::IdWidth-1:0]  out_id_o,
  output logic                         out_new_o,
  output logic                         out_ovf_o
);
  import uka_pkg::*;

  localparam int PosWidth = $clog2(TableDepth + 1);
  localparam logic [PosWidth-1:0] Full = PosWidth'(TableDepth);

  state_e              state_q, state_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [PosWidth-1:0] used_q, used_d;
  logic [IdWidth-1:0]  pend_id_q, pend_id_d;
  logic                pend_new_q, pend_new_d;
  logic                pend_ovf_q, pend_ovf_d;
  logic                out_valid_q, out_valid_d;
  logic [IdWidth-1:0]  out_id_q;
  logic                out_new_q;
  logic                out_ovf_q;
  logic                load_out;
  logic [IdWidth+PosWidth-1:0] pos_ext;

  assign pos_ext = {{IdWidth{1'b0}}, pos_q};

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    used_d      = used_q;
    pend_id_d   = pend_id_q;
    pend_new_d  = pend_new_q;
    pend_ovf_d  = pend_ovf_q;
    ctrl_o      = '0;
    in_ready_o  = 1'b0;
    load_out    = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pos_d   = '0;
          state_d = StWalk;
          if (start_i) begin
            used_d = '0;
          end
        end
      end
      StWalk: begin
        if (pos_q == used_q) begin
          ctrl_o.flush = 1'b1;
          state_d      = StDone;
          if (used_q != Full) begin
            ctrl_o.insert = 1'b1;
            used_d        = used_q + 1'b1;
            pend_id_d     = pos_ext[IdWidth-1:0];
            pend_new_d    = 1'b1;
            pend_ovf_d    = 1'b0;
          end else begin
            pend_id_d  = '0;
            pend_new_d = 1'b0;
            pend_ovf_d = 1'b1;
          end
        end else if (hit_i) begin
          ctrl_o.flush = 1'b1;
          state_d      = StDone;
          pend_id_d    = pos_ext[IdWidth-1:0];
          pend_new_d   = 1'b0;
          pend_ovf_d   = 1'b0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_id_q  <= pend_id_d;
    pend_new_q <= pend_new_d;
    pend_ovf_q <= pend_ovf_d;
    if (load_out) begin
      out_id_q  <= pend_id_q;
      out_new_q <= pend_new_q;
      out_ovf_q <= pend_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_id_o    = out_id_q;
  assign out_new_o   = out_new_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

/* rtl/uka_checker.sv */
module uka_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("new type and overflow together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 8'd0)
    else $error("overflow with nonzero id");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while walk in progress");

endmodule

bind unique_key_id_assigner uka_checker u_uka_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
